// ===== rtl/bdq_pkg.sv =====
package bdq_pkg;

   localparam int unsigned DEPTH_DEFAULT = 16;
   localparam int unsigned DATA_W        = 32;
   localparam int unsigned CMD_W         = 3;
   localparam int unsigned STATUS_W      = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH_FRONT = 3'd0,
      CMD_PUSH_REAR  = 3'd1,
      CMD_POP_FRONT  = 3'd2,
      CMD_POP_REAR   = 3'd3,
      CMD_PEEK_FRONT = 3'd4,
      CMD_PEEK_REAR  = 3'd5,
      CMD_DUMP_FWD   = 3'd6,
      CMD_DUMP_BWD   = 3'd7
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_EMPTY   = 2'd1,
      ST_REFUSED = 2'd2
   } status_type;

   // One result as it leaves the controller.
   typedef struct packed {
      logic signed [DATA_W-1:0] data_out;
      status_type               status;
      logic                     empty_flag;
      logic                     full_flag;
      logic                     last;
   } rsp_item_type;

endpackage

// ===== rtl/bdq_mem.sv =====
module bdq_mem import bdq_pkg::*; #(
   parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [DATA_W-1:0]          wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [DATA_W-1:0]          rd_data
);

   logic [DATA_W-1:0] slots [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // Read data is registered and holds until the next read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slots[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= slots[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/bdq_ctrl.sv =====
module bdq_ctrl import bdq_pkg::*; #(
   parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [CMD_W-1:0]           req_cmd,
   input  logic [DATA_W-1:0]          req_data,
   output logic                       item_valid,
   input  logic                       item_ready,
   output rsp_item_type               item,
   output logic                       wr_en,
   output logic [$clog2(DEPTH)-1:0]   wr_addr,
   output logic [DATA_W-1:0]          wr_data,
   output logic                       rd_en,
   output logic [$clog2(DEPTH)-1:0]   rd_addr,
   input  logic [DATA_W-1:0]          rd_data
);

   localparam int unsigned AW = $clog2(DEPTH);
   localparam int unsigned PW = $clog2(DEPTH + 1);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_RESP = 3'b010,
      S_DUMP = 3'b100
   } state_type;

   state_type       state_ff, state_in;
   logic [PW-1:0]   front_ff, front_in;
   logic [PW-1:0]   rear_ff, rear_in;
   logic            started_ff, started_in;
   status_type      status_ff, status_in;
   logic            use_rd_ff, use_rd_in;
   logic [AW-1:0]   walk_ff, walk_in;
   logic [AW-1:0]   walk_end_ff, walk_end_in;
   logic            walk_fwd_ff, walk_fwd_in;

   logic [PW-1:0]   front_dec;
   logic [PW-1:0]   rear_dec;
   logic [AW-1:0]   walk_next;
   logic            deque_empty;
   logic            is_full;
   logic            walk_last;

   assign front_dec = front_ff - PW'(1);
   assign rear_dec  = rear_ff - PW'(1);
   assign walk_next = walk_fwd_ff ? (walk_ff + AW'(1)) : (walk_ff - AW'(1));
   assign walk_last = (walk_ff == walk_end_ff);

   // The front never passes the rear, so equal indexes mean empty.
   assign deque_empty = (front_ff == rear_ff);
   assign is_full     = (front_ff == '0) && (rear_ff == PW'(DEPTH));

   assign wr_data = req_data;

   always_comb begin
      state_in    = state_ff;
      front_in    = front_ff;
      rear_in     = rear_ff;
      started_in  = started_ff;
      status_in   = status_ff;
      use_rd_in   = use_rd_ff;
      walk_in     = walk_ff;
      walk_end_in = walk_end_ff;
      walk_fwd_in = walk_fwd_ff;
      req_ready   = 1'b0;
      item_valid  = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = '0;
      rd_en       = 1'b0;
      rd_addr     = '0;

      item.data_out   = '0;
      item.status     = ST_OK;
      item.empty_flag = deque_empty;
      item.full_flag  = is_full;
      item.last       = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               status_in = ST_OK;
               use_rd_in = 1'b0;
               state_in  = S_RESP;
               unique case (cmd_type'(req_cmd))
                  CMD_PUSH_FRONT: begin
                     if (!started_ff) begin
                        started_in = 1'b1;
                        front_in   = '0;
                        rear_in    = PW'(1);
                        wr_en      = 1'b1;
                        wr_addr    = '0;
                     end else if (front_ff == '0) begin
                        status_in = ST_REFUSED;
                     end else begin
                        front_in = front_dec;
                        wr_en    = 1'b1;
                        wr_addr  = front_dec[AW-1:0];
                     end
                  end
                  CMD_PUSH_REAR: begin
                     if (rear_ff == PW'(DEPTH)) begin
                        status_in = ST_REFUSED;
                     end else begin
                        started_in = 1'b1;
                        wr_en      = 1'b1;
                        wr_addr    = rear_ff[AW-1:0];
                        rear_in    = rear_ff + PW'(1);
                     end
                  end
                  CMD_POP_FRONT, CMD_PEEK_FRONT: begin
                     if (deque_empty) begin
                        status_in = ST_EMPTY;
                     end else begin
                        rd_en     = 1'b1;
                        rd_addr   = front_ff[AW-1:0];
                        use_rd_in = 1'b1;
                        if (cmd_type'(req_cmd) == CMD_POP_FRONT) begin
                           front_in = front_ff + PW'(1);
                        end
                     end
                  end
                  CMD_POP_REAR, CMD_PEEK_REAR: begin
                     if (deque_empty) begin
                        status_in = ST_EMPTY;
                     end else begin
                        rd_en     = 1'b1;
                        rd_addr   = rear_dec[AW-1:0];
                        use_rd_in = 1'b1;
                        if (cmd_type'(req_cmd) == CMD_POP_REAR) begin
                           rear_in = rear_dec;
                        end
                     end
                  end
                  CMD_DUMP_FWD, CMD_DUMP_BWD: begin
                     if (deque_empty) begin
                        status_in = ST_EMPTY;
                     end else begin
                        walk_fwd_in = (cmd_type'(req_cmd) == CMD_DUMP_FWD);
                        walk_in     = walk_fwd_in ? front_ff[AW-1:0] : rear_dec[AW-1:0];
                        walk_end_in = walk_fwd_in ? rear_dec[AW-1:0] : front_ff[AW-1:0];
                        rd_en       = 1'b1;
                        rd_addr     = walk_in;
                        state_in    = S_DUMP;
                     end
                  end
               endcase
            end
         end
         S_RESP: begin
            item_valid    = 1'b1;
            item.data_out = use_rd_ff ? rd_data : '0;
            item.status   = status_ff;
            if (item_ready) begin
               state_in = S_IDLE;
            end
         end
         S_DUMP: begin
            item_valid    = 1'b1;
            item.data_out = rd_data;
            item.last     = walk_last;
            if (item_ready) begin
               if (walk_last) begin
                  state_in = S_IDLE;
               end else begin
                  // Fetch the next word while this one is handed off.
                  rd_en   = 1'b1;
                  rd_addr = walk_next;
                  walk_in = walk_next;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         front_ff   <= '0;
         rear_ff    <= '0;
         started_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         front_ff   <= front_in;
         rear_ff    <= rear_in;
         started_ff <= started_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff   <= status_in;
      use_rd_ff   <= use_rd_in;
      walk_ff     <= walk_in;
      walk_end_ff <= walk_end_in;
      walk_fwd_ff <= walk_fwd_in;
   end

endmodule

// ===== rtl/bounded_array_deque.sv =====
// Push, pop and peek: the result of a taken request goes through the controller's response state
// into the output register; no new request is taken until the last result has been loaded.
// A dump reads one word per cycle from the single read port of the slot memory, while the output
// register accepts them. Synchronous active-high reset clears the front and rear indexes, the
// started mark and all handshake state. Slot memory is not cleared and needs no clearing pass.
module bounded_array_deque import bdq_pkg::*; #(
   parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] data_in
   input  logic [2:0]  req_tuser,   // [2:0] cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] data_out, [32] empty_flag, [33] full_flag, zero pad
   output logic [1:0]  rsp_tuser,   // [1:0] status
   output logic        rsp_tlast
);

   // The controller takes one request at a time. Each request is handled by a
   // short sequence: first it is decoded, the indexes are updated and a memory
   // access is started; then its results are handed off one by one. Writes and
   // reads to the same slot can never overlap, because the next request is not
   // taken until the current one has handed off its last result.
   localparam int unsigned AW = $clog2(DEPTH);

   logic               item_valid;
   logic               item_ready;
   rsp_item_type       item;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [DATA_W-1:0]  wr_data;
   logic               rd_en;
   logic [AW-1:0]      rd_addr;
   logic [DATA_W-1:0]  rd_data;

   logic               rsp_valid_ff;
   rsp_item_type       rsp_item_ff;

   bdq_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_cmd    (req_tuser),
      .req_data   (req_tdata),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .item       (item),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data)
   );

   bdq_mem #(
      .DEPTH (DEPTH)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Output register: the controller may load a new result whenever the
   // register is empty or its current result is being taken in this cycle.
   assign item_ready = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (item_valid && item_ready) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (item_valid && item_ready) begin
         rsp_item_ff <= item;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_item_ff.full_flag, rsp_item_ff.empty_flag,
                        rsp_item_ff.data_out};
   assign rsp_tuser  = rsp_item_ff.status;
   assign rsp_tlast  = rsp_item_ff.last;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import bdq_pkg::*;

   localparam int unsigned DQ_DEPTH = DEPTH_DEFAULT;

   // Clock, reset and both stream channels of the deque.
   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // [31:0] data_in
   logic [2:0]  req_tuser;   // [2:0] cmd
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;   // [31:0] data_out, [32] empty_flag, [33] full_flag, zero pad
   logic [1:0]  rsp_tuser;   // [1:0] status
   logic        rsp_tlast;

   bounded_array_deque #(.DEPTH(DQ_DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // The testbench's own copy of the deque. The slot array starts at zero, but only slots
   // that hold a word are ever read, so that value never reaches a response.
   logic [31:0] slot_mem [DQ_DEPTH];
   int unsigned front_idx;
   int unsigned rear_next;   // one past the rear word
   bit          has_started;

   // Responses that the deque still owes, oldest first.
   rsp_item_type deque_rsp_q[$];

   int  mismatches;
   bit  req_gaps_on;   // the request side may pause between requests
   bit  allow_idle;    // either side may idle at all; cleared for the final stretch

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Generous upper bound: every request followed by a full sixteen-word dump, every
   // response held back by the longest stall, and the longest pause between requests,
   // taken about five times over.
   initial begin
      #10_000_000;
      $display("Verification failed");
      $finish;
   end

   function automatic bit deque_vacant();
      return !has_started || front_idx >= rear_next;
   endfunction

   function automatic bit deque_is_full();
      return has_started && front_idx == 0 && rear_next == DQ_DEPTH;
   endfunction

   // Puts one response on the queue, with the flags as the deque stands now.
   task automatic queue_response(input logic [31:0] word, input status_type st,
                                 input bit is_last);
      rsp_item_type r;
      r.data_out   = word;
      r.status     = st;
      r.empty_flag = deque_vacant();
      r.full_flag  = deque_is_full();
      r.last       = is_last;
      deque_rsp_q.push_back(r);
   endtask

   // Applies one accepted request to the copy of the deque and queues what it must answer.
   task automatic deque_apply_request(input cmd_type cmd, input logic [31:0] word);
      logic [31:0] rd_word;
      status_type  st;
      int unsigned i;
      int unsigned idx;
      bit          dumped;
      rd_word = '0;
      st      = ST_OK;
      dumped  = 1'b0;
      case (cmd)
         CMD_PUSH_FRONT: begin
            // The very first word always lands in slot 0. After that the front
            // moves down only on a push at the front, and it cannot move below slot 0.
            if (!has_started) begin
               has_started = 1'b1;
               front_idx   = 0;
               rear_next   = 1;
               slot_mem[0] = word;
            end else if (front_idx == 0) begin
               st = ST_REFUSED;
            end else begin
               front_idx--;
               slot_mem[front_idx] = word;
            end
         end
         CMD_PUSH_REAR: begin
            if (rear_next >= DQ_DEPTH) begin
               st = ST_REFUSED;
            end else begin
               if (!has_started) begin
                  has_started = 1'b1;
                  front_idx   = 0;
               end
               slot_mem[rear_next] = word;
               rear_next++;
            end
         end
         CMD_POP_FRONT: begin
            if (deque_vacant()) begin
               st = ST_EMPTY;
            end else begin
               rd_word = slot_mem[front_idx];
               front_idx++;
            end
         end
         CMD_POP_REAR: begin
            if (deque_vacant()) begin
               st = ST_EMPTY;
            end else begin
               rear_next--;
               rd_word = slot_mem[rear_next];
            end
         end
         CMD_PEEK_FRONT: begin
            if (deque_vacant()) st = ST_EMPTY;
            else rd_word = slot_mem[front_idx];
         end
         CMD_PEEK_REAR: begin
            if (deque_vacant()) st = ST_EMPTY;
            else rd_word = slot_mem[rear_next - 1];
         end
         default: begin
            // A dump answers once per held word, front to rear or rear to front, and
            // marks the final word. On an empty deque it answers once, like a pop.
            if (deque_vacant()) begin
               st = ST_EMPTY;
            end else begin
               dumped = 1'b1;
               for (i = front_idx; i < rear_next; i++) begin
                  idx = (cmd == CMD_DUMP_FWD) ? i : rear_next - 1 - (i - front_idx);
                  queue_response(slot_mem[idx], ST_OK, i + 1 >= rear_next);
               end
            end
         end
      endcase
      if (!dumped) queue_response(rd_word, st, 1'b1);
   endtask

   // Drives one request at the falling edge, sometimes after a pause, and holds it until
   // the deque takes it. The valid is left high so that a following request can ride on
   // it without a bubble.
   task automatic send_request(input cmd_type cmd, input logic [31:0] word);
      int unsigned gap;
      gap = 0;
      if (req_gaps_on && allow_idle && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 17);
      @(negedge clock);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= word;
      do @(posedge clock); while (!req_tready);
      deque_apply_request(cmd, word);
   endtask

   // Lowers the valid and holds off until every owed response has come back.
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (deque_rsp_q.size() != 0) @(posedge clock);
   endtask

   // Data words lean toward the extremes of the signed range now and then.
   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 7))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // Picks a command with a given share of pushes; the rest spread over the others.
   function automatic cmd_type pick_cmd(input int unsigned push_pct);
      if ($urandom_range(0, 99) < push_pct)
         return $urandom_range(0, 1) ? CMD_PUSH_REAR : CMD_PUSH_FRONT;
      return cmd_type'($urandom_range(2, 7));
   endfunction

   // Every removal, peek and dump on a deque that was never written.
   task automatic test_empty_deque();
      send_request(CMD_POP_FRONT,  pick_word());
      send_request(CMD_POP_REAR,   pick_word());
      send_request(CMD_PEEK_FRONT, pick_word());
      send_request(CMD_PEEK_REAR,  pick_word());
      send_request(CMD_DUMP_FWD,   pick_word());
      send_request(CMD_DUMP_BWD,   pick_word());
   endtask

   // The first insert, refusals at slot 0, both ends on a two-word deque, and pushes after
   // the deque has been emptied again.
   task automatic test_deque_ends();
      send_request(CMD_PUSH_FRONT, 32'h7FFF_FFFF);   // first insert goes to slot 0
      send_request(CMD_PUSH_FRONT, 32'h0000_0000);   // front already at slot 0
      send_request(CMD_PUSH_REAR,  32'h8000_0000);
      send_request(CMD_PEEK_FRONT, 32'hFFFF_FFFF);
      send_request(CMD_PEEK_REAR,  32'h0000_0000);
      send_request(CMD_DUMP_FWD,   32'hFFFF_FFFF);
      send_request(CMD_DUMP_BWD,   32'h0000_0000);
      send_request(CMD_POP_FRONT,  32'hFFFF_FFFF);
      send_request(CMD_POP_REAR,   32'h0000_0000);   // now empty with front and rear at 1
      send_request(CMD_PUSH_FRONT, 32'hFFFF_FFFF);   // lone word drops into slot 0
      send_request(CMD_POP_REAR,   32'h8000_0000);   // empty again, front at slot 0
      send_request(CMD_PUSH_FRONT, 32'h7FFF_FFFF);   // refused even though empty
   endtask

   // Fills the whole array from the rear, hits both refusals while full, dumps it both
   // ways and drains it from random ends.
   task automatic test_fill_to_full();
      int n;
      wait_drained();
      for (n = 0; n < DQ_DEPTH; n++) send_request(CMD_PUSH_REAR, pick_word());
      send_request(CMD_PUSH_REAR,  pick_word());
      send_request(CMD_PUSH_FRONT, pick_word());
      send_request(CMD_DUMP_BWD,   pick_word());
      send_request(CMD_DUMP_FWD,   pick_word());
      for (n = 0; n < DQ_DEPTH; n++)
         send_request($urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_REAR, pick_word());
      send_request(CMD_PEEK_FRONT, pick_word());
   endtask

   // Random traffic in episodes that lean toward filling, draining or neither, so that the
   // indexes wander over the whole array. Request pauses switch on and off per episode.
   task automatic test_random_traffic(input int unsigned n_requests);
      int unsigned sent;
      int unsigned ep_len;
      int unsigned push_pct;
      int unsigned k;
      sent = 0;
      while (sent < n_requests) begin
         case ($urandom_range(0, 2))
            0:       push_pct = 75;
            1:       push_pct = 20;
            default: push_pct = 45;
         endcase
         req_gaps_on = 1'($urandom_range(0, 1));
         ep_len      = $urandom_range(8, 40);
         for (k = 0; k < ep_len && sent < n_requests; k++) begin
            send_request(pick_cmd(push_pct), pick_word());
            sent++;
         end
      end
      req_gaps_on = 1'b1;
   endtask

   // The last stretch runs at full rate on both sides.
   task automatic test_full_rate(input int unsigned n_requests);
      int unsigned k;
      allow_idle = 1'b0;
      for (k = 0; k < n_requests; k++) send_request(pick_cmd(45), pick_word());
   endtask

   // The response side stalls in bursts, with calm stretches between.
   initial begin : rsp_stall_gen
      int unsigned stall_left;
      int unsigned calm_left;
      stall_left = 0;
      calm_left  = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (!allow_idle) begin
            rsp_tready <= 1'b1;
         end else if (stall_left != 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else if (calm_left != 0) begin
            rsp_tready <= 1'b1;
            calm_left--;
         end else begin
            case ($urandom_range(0, 2))
               0: begin
                  rsp_tready <= 1'b0;
                  stall_left = $urandom_range(1, 17) - 1;
               end
               1: begin
                  rsp_tready <= 1'b1;
                  calm_left = $urandom_range(10, 60);
               end
               default: rsp_tready <= 1'b1;
            endcase
         end
      end
   end

   task automatic check_field(input string name, input logic [31:0] exp_val,
                              input logic [31:0] act_val);
      if (exp_val !== act_val) begin
         $error("%s mismatch: expected %0h, actual %0h", name, exp_val, act_val);
         mismatches++;
      end
   endtask

   // Every response taken at a rising edge is compared with the oldest one still owed.
   always @(posedge clock) begin : rsp_check
      rsp_item_type exp_rsp;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (deque_rsp_q.size() == 0) begin
            $error("response with none owed: data_out %0h, status %0d",
                   rsp_tdata[31:0], rsp_tuser);
            mismatches++;
         end else begin
            exp_rsp = deque_rsp_q.pop_front();
            check_field("data_out",   exp_rsp.data_out, rsp_tdata[31:0]);
            check_field("status",     32'(exp_rsp.status), 32'(rsp_tuser));
            check_field("empty_flag", 32'(exp_rsp.empty_flag), 32'(rsp_tdata[32]));
            check_field("full_flag",  32'(exp_rsp.full_flag), 32'(rsp_tdata[33]));
            check_field("last",       32'(exp_rsp.last), 32'(rsp_tlast));
         end
      end
   end

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = CMD_PUSH_FRONT;
      mismatches  = 0;
      req_gaps_on = 1'b1;
      allow_idle  = 1'b1;
      has_started = 1'b0;
      front_idx   = 0;
      rear_next   = 0;
      foreach (slot_mem[i]) slot_mem[i] = '0;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_deque();
      test_deque_ends();
      test_fill_to_full();
      test_random_traffic(400);
      test_full_rate(40);

      // Let every owed response arrive, then give the deque time to show any extra one;
      // a full dump is the longest thing it does.
      wait_drained();
      repeat (40) @(posedge clock);
      if (mismatches == 0 && deque_rsp_q.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
